@@ rtl/tplc_pkg.sv @@
// ----------------------------------------------------------------------------
// tplc_pkg
// Shared types and constants of the two-phase traffic light controller.
// ----------------------------------------------------------------------------
package tplc_pkg;

  localparam int unsigned MaxCodes  = 5;
  localparam int unsigned MaxDigits = 4;

  localparam logic [4:0] M_INIT    = 5'd0;
  localparam logic [4:0] M_ENTER   = 5'd1;
  localparam logic [4:0] M_CHECK   = 5'd2;
  localparam logic [4:0] M_WRONG   = 5'd3;
  localparam logic [4:0] M_IDLE    = 5'd4;
  localparam logic [4:0] M_SETTIME = 5'd5;
  localparam logic [4:0] M_SG1     = 5'd6;
  localparam logic [4:0] M_SY1     = 5'd7;
  localparam logic [4:0] M_SG2     = 5'd8;
  localparam logic [4:0] M_SY2     = 5'd9;
  localparam logic [4:0] M_START   = 5'd10;
  localparam logic [4:0] M_G1R2    = 5'd11;
  localparam logic [4:0] M_Y1R2    = 5'd12;
  localparam logic [4:0] M_R1G2    = 5'd13;
  localparam logic [4:0] M_R1Y2    = 5'd14;
  localparam logic [4:0] M_SLOW    = 5'd15;
  localparam logic [4:0] M_MANUAL  = 5'd16;
  localparam logic [4:0] M_WALK    = 5'd17;

  localparam logic [2:0] LG = 3'd1;
  localparam logic [2:0] LY = 3'd2;
  localparam logic [2:0] LR = 3'd4;
  localparam logic [2:0] L0 = 3'd0;

  localparam logic [2:0] G1 = 3'd0;
  localparam logic [2:0] Y1 = 3'd1;
  localparam logic [2:0] R1 = 3'd2;
  localparam logic [2:0] G2 = 3'd3;
  localparam logic [2:0] Y2 = 3'd4;
  localparam logic [2:0] R2 = 3'd5;

  localparam logic [2:0] S_FRESH = 3'd0;
  localparam logic [2:0] S_NIGHT = 3'd1;
  localparam logic [2:0] S_KEY   = 3'd2;
  localparam logic [2:0] S_LEFT  = 3'd3;

  localparam logic [3:0] CFG_CODE0 = 4'd0;
  localparam logic [3:0] CFG_CODE1 = 4'd1;
  localparam logic [3:0] CFG_CODE2 = 4'd2;
  localparam logic [3:0] CFG_CODE3 = 4'd3;
  localparam logic [3:0] CFG_CODE4 = 4'd4;
  localparam logic [3:0] CFG_TPS   = 4'd5;
  localparam logic [3:0] CFG_ENTRY = 4'd6;
  localparam logic [3:0] CFG_SET   = 4'd7;

  typedef struct packed {
    logic [MaxCodes-1:0][15:0] code;
    logic [7:0]                tps;
    logic [11:0]               entry_to;
    logic [11:0]               set_to;
  } tplc_cfg_t;

  typedef struct packed {
    logic       confirm_btn;
    logic       delete_btn;
    logic       set_time_btn;
    logic       manual_btn;
    logic       slow_btn;
    logic       walk_req_one;
    logic       walk_req_two;
    logic       digit_valid;
    logic [3:0] digit_value;
    logic [4:0] hour_now;
  } tplc_in_t;

  typedef struct packed {
    logic [2:0] lamps_one;
    logic [2:0] lamps_two;
    logic [6:0] count_one;
    logic [6:0] count_two;
    logic [4:0] mode_code;
    logic       unlocked;
  } tplc_out_t;

  typedef struct packed {
    logic [4:0]                 main_mode;
    logic [4:0]                 return_mode;
    logic [4:0]                 target_mode;
    logic [2:0]                 manual_step;
    logic [2:0]                 walk_step;
    logic [2:0]                 slow_step;
    logic [7:0]                 tick_count;
    logic                       second_strobe;
    logic [11:0]                idle_count;
    logic [3:0]                 digit_index;
    logic [MaxDigits-1:0][3:0]  entered_code;
    logic [1:0][3:0]            entered_time;
    logic [5:0][6:0]            preset;
    logic [5:0][6:0]            run;
    logic [1:0][2:0]            lamp;
    logic                       flash_toggle;
    logic                       times_set;
    logic                       unlock_flag;
  } tplc_state_t;

endpackage

@@ rtl/two_phase_traffic_light_controller.sv @@
// ----------------------------------------------------------------------------
// two_phase_traffic_light_controller
// Keypad-driven two-phase traffic light controller, one loop tick per transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one control-loop tick; its result (lamps, shown
// counts, mode, unlock flag) appears in the output register on the next
// cycle. A tick is taken every cycle while the output register is free or
// being drained: throughput is one tick per clock. The result register is
// loaded from the step logic. The user writes configuration through
// cfg_we_i/cfg_idx_i/cfg_data_i only while idle; the block does not enforce it.
module two_phase_traffic_light_controller import tplc_pkg::*; #(
  parameter int unsigned NUM_CODES   = MaxCodes,
  parameter int unsigned CODE_DIGITS = MaxDigits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        confirm_btn_i,
  input  logic        delete_btn_i,
  input  logic        set_time_btn_i,
  input  logic        manual_btn_i,
  input  logic        slow_btn_i,
  input  logic        walk_req_one_i,
  input  logic        walk_req_two_i,
  input  logic        digit_valid_i,
  input  logic [3:0]  digit_value_i,
  input  logic [4:0]  hour_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  lamps_one_o,
  output logic [2:0]  lamps_two_o,
  output logic [6:0]  count_one_o,
  output logic [6:0]  count_two_o,
  output logic [4:0]  mode_code_o,
  output logic        unlocked_o
);

  tplc_cfg_t   cfg;
  tplc_in_t    in_w;
  tplc_state_t state_q, state_d;
  tplc_out_t   res_q, res_d;
  logic        out_valid_q, out_valid_d;
  logic        in_accept;

  tplc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  assign in_w.confirm_btn  = confirm_btn_i;
  assign in_w.delete_btn   = delete_btn_i;
  assign in_w.set_time_btn = set_time_btn_i;
  assign in_w.manual_btn   = manual_btn_i;
  assign in_w.slow_btn     = slow_btn_i;
  assign in_w.walk_req_one = walk_req_one_i;
  assign in_w.walk_req_two = walk_req_two_i;
  assign in_w.digit_valid  = digit_valid_i;
  assign in_w.digit_value  = digit_value_i;
  assign in_w.hour_now     = hour_now_i;

  tplc_step #(
    .NUM_CODES   (NUM_CODES),
    .CODE_DIGITS (CODE_DIGITS)
  ) u_step (
    .st_i  (state_q),
    .cfg_i (cfg),
    .in_i  (in_w),
    .st_o  (state_d),
    .res_o (res_d)
  );

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign out_valid_d = in_accept | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_accept) state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) res_q <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign lamps_one_o = res_q.lamps_one;
  assign lamps_two_o = res_q.lamps_two;
  assign count_one_o = res_q.count_one;
  assign count_two_o = res_q.count_two;
  assign mode_code_o = res_q.mode_code;
  assign unlocked_o  = res_q.unlocked;

`ifndef SYNTH
  a_accept_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> out_valid_q)
    else $error("accepted tick produced no result");

  a_hold_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_accept |=> $stable(state_q))
    else $error("state changed without a transfer");

  a_unlock_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.unlock_flag) |-> $past(state_q.main_mode) == M_CHECK)
    else $error("unlock set outside password check");
`endif

endmodule

@@ rtl/tplc_cfg.sv @@
// ----------------------------------------------------------------------------
// tplc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module tplc_cfg import tplc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  output tplc_cfg_t   cfg_o
);

  tplc_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CODE0: cfg_d.code[0]  = cfg_data_i;
        CFG_CODE1: cfg_d.code[1]  = cfg_data_i;
        CFG_CODE2: cfg_d.code[2]  = cfg_data_i;
        CFG_CODE3: cfg_d.code[3]  = cfg_data_i;
        CFG_CODE4: cfg_d.code[4]  = cfg_data_i;
        CFG_TPS:   cfg_d.tps      = cfg_data_i[7:0];
        CFG_ENTRY: cfg_d.entry_to = cfg_data_i[11:0];
        CFG_SET:   cfg_d.set_to   = cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q          <= '0;
      cfg_q.tps      <= 8'd20;
      cfg_q.entry_to <= 12'd200;
      cfg_q.set_to   <= 12'd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/tplc_step.sv @@
// ----------------------------------------------------------------------------
// tplc_step
// Next-state and result logic for one control-loop tick.
// ----------------------------------------------------------------------------
module tplc_step import tplc_pkg::*; #(
  parameter int unsigned NUM_CODES   = MaxCodes,
  parameter int unsigned CODE_DIGITS = MaxDigits
) (
  input  tplc_state_t st_i,
  input  tplc_cfg_t   cfg_i,
  input  tplc_in_t    in_i,
  output tplc_state_t st_o,
  output tplc_out_t   res_o
);

  function automatic tplc_state_t lclr(tplc_state_t s, logic [2:0] m1, logic [2:0] m2);
    s.lamp[0] = s.lamp[0] & ~m1;
    s.lamp[1] = s.lamp[1] & ~m2;
    return s;
  endfunction

  function automatic tplc_state_t lset(tplc_state_t s, logic [2:0] m1, logic [2:0] m2);
    s.lamp[0] = s.lamp[0] | m1;
    s.lamp[1] = s.lamp[1] | m2;
    return s;
  endfunction

  function automatic tplc_state_t dec(tplc_state_t s, logic [2:0] i);
    if (s.run[i] != 7'd0) s.run[i] = s.run[i] - 7'd1;
    return s;
  endfunction

  function automatic tplc_state_t reload(tplc_state_t s, logic [2:0] i);
    s.run[i] = s.preset[i];
    return s;
  endfunction

  function automatic tplc_state_t idle_inc(tplc_state_t s);
    if (s.idle_count != 12'hFFF) s.idle_count = s.idle_count + 12'd1;
    return s;
  endfunction

  function automatic tplc_state_t idx_inc(tplc_state_t s);
    if (s.digit_index != 4'hF) s.digit_index = s.digit_index + 4'd1;
    return s;
  endfunction

  function automatic tplc_state_t req_set_time(tplc_state_t s, logic save, logic [4:0] cur,
                                               logic [2:0] m1, logic [2:0] m2);
    if (save) s.return_mode = cur;
    s = lclr(s, m1, m2);
    s.main_mode   = M_ENTER;
    s.target_mode = M_SETTIME;
    return s;
  endfunction

  function automatic tplc_state_t req_manual(tplc_state_t s, logic [4:0] cur);
    s.return_mode = cur;
    s.lamp        = '0;
    s.main_mode   = M_ENTER;
    s.target_mode = M_MANUAL;
    s.manual_step = 3'd0;
    return s;
  endfunction

  function automatic tplc_state_t req_slow(tplc_state_t s, logic [4:0] cur, logic slw,
                                           logic nt, logic always_tgt);
    if ((slw || nt) && s.slow_step != S_LEFT) begin
      s.return_mode = cur;
      s.lamp        = '0;
      if (slw) begin
        s.main_mode   = M_ENTER;
        s.target_mode = M_SLOW;
      end else begin
        s.main_mode = M_SLOW;
      end
      if (always_tgt) s.target_mode = M_SLOW;
      s.slow_step = S_FRESH;
    end
    return s;
  endfunction

  function automatic tplc_state_t req_del(tplc_state_t s, logic [4:0] cur, logic del);
    if (s.slow_step == S_LEFT && del) begin
      s.return_mode = cur;
      s.lamp        = '0;
      s.main_mode   = M_ENTER;
      s.target_mode = M_SLOW;
      s.slow_step   = S_NIGHT;
    end
    return s;
  endfunction

  function automatic tplc_state_t setting_common(tplc_state_t s, logic stb, logic [11:0] to);
    if (stb) begin
      s.lamp      = '0;
      s.main_mode = M_SETTIME;
    end
    if (s.idle_count > to) begin
      s.main_mode  = M_IDLE;
      s.idle_count = '0;
    end
    return s;
  endfunction

  function automatic tplc_state_t set_green(tplc_state_t s, logic [2:0] gi, logic [4:0] nxt,
                                            tplc_in_t x, logic [11:0] to);
    logic [7:0] v;
    s = idle_inc(s);
    if (x.digit_valid) begin
      if (s.digit_index < 4'd2) s.entered_time[s.digit_index[0]] = x.digit_value;
      s = idx_inc(s);
    end
    if (x.delete_btn) s.digit_index = '0;
    if (x.confirm_btn) begin
      if (s.digit_index == 4'd1) v = 8'd10;
      else v = 8'(s.entered_time[0]) * 8'd10 + 8'(s.entered_time[1]);
      if (v > 8'd90) v = 8'd90;
      s.run[gi]      = v[6:0];
      s.preset[gi]   = v[6:0];
      s.digit_index  = '0;
      s.main_mode    = nxt;
    end
    s = setting_common(s, x.set_time_btn, to);
    return s;
  endfunction

  function automatic tplc_state_t set_yellow(tplc_state_t s, logic [2:0] gi, logic [2:0] yi,
                                             logic [2:0] ri, logic last, tplc_in_t x,
                                             logic [11:0] to);
    s = idle_inc(s);
    if (x.digit_valid) begin
      if (s.digit_index < 4'd1) s.entered_time[0] = x.digit_value;
      s = idx_inc(s);
      s.idle_count = '0;
    end
    if (x.delete_btn) s.digit_index = '0;
    if (x.confirm_btn) begin
      s.digit_index = '0;
      s.run[yi]     = 7'(s.entered_time[0]);
      s.preset[yi]  = 7'(s.entered_time[0]);
      s.run[ri]     = s.run[gi] + s.run[yi];
      s.preset[ri]  = s.run[ri];
      if (last) begin
        s.times_set = 1'b1;
        s.main_mode = M_IDLE;
      end else begin
        s.main_mode = M_SG2;
      end
    end
    s = setting_common(s, x.set_time_btn, to);
    return s;
  endfunction

  tplc_state_t s;
  logic        nt, strobe, match, ok;
  logic [6:0]  c1, c2;

  always_comb begin
    match = 1'b0;
    ok    = 1'b0;
    for (int k = 0; k < NUM_CODES; k++) begin
      ok = 1'b1;
      for (int d = 0; d < CODE_DIGITS; d++) begin
        if (st_i.entered_code[d] != cfg_i.code[k][15-4*d -: 4]) ok = 1'b0;
      end
      if (ok) match = 1'b1;
    end
  end

  always_comb begin
    s  = st_i;
    c1 = '0;
    c2 = '0;
    nt = (in_i.hour_now <= 5'd4) || (in_i.hour_now == 5'd23);

    s.tick_count = s.tick_count + 8'd1;
    if (cfg_i.tps != 8'd0 && s.tick_count >= cfg_i.tps) s.tick_count = '0;
    if (s.tick_count == 8'd0) s.second_strobe = 1'b1;
    strobe = s.second_strobe;

    unique case (st_i.main_mode)
      M_INIT: begin
        s.lamp = '0;
        if (in_i.confirm_btn) begin
          s.digit_index = '0;
          s.idle_count  = '0;
          s.main_mode   = M_ENTER;
          s.return_mode = M_INIT;
        end
      end
      M_ENTER: begin
        s = idle_inc(s);
        if (in_i.digit_valid && !in_i.delete_btn) begin
          if (s.digit_index < 4'(CODE_DIGITS))
            s.entered_code[s.digit_index[1:0]] = in_i.digit_value;
          s = idx_inc(s);
          s.idle_count = '0;
        end
        if (in_i.delete_btn) begin
          s.digit_index = '0;
          s.idle_count  = '0;
        end
        if (in_i.confirm_btn) s.main_mode = M_CHECK;
        if (s.idle_count >= cfg_i.entry_to) begin
          s.main_mode   = s.return_mode;
          s.idle_count  = '0;
          s.digit_index = '0;
        end
      end
      M_CHECK: begin
        s.idle_count = '0;
        if (match) begin
          if (s.target_mode == 5'd0) s.main_mode = M_IDLE;
          else if (s.target_mode == M_SETTIME) s.main_mode = M_SETTIME;
          else if (s.target_mode == M_SLOW) s.main_mode = M_SLOW;
          else s.main_mode = M_MANUAL;
          s.unlock_flag = 1'b1;
          s.digit_index = '0;
        end else begin
          s.main_mode = M_WRONG;
        end
      end
      M_WRONG: begin
        s = idle_inc(s);
        if (in_i.confirm_btn) begin
          s.digit_index = '0;
          s.idle_count  = '0;
          s.main_mode   = M_ENTER;
        end
      end
      M_IDLE: begin
        s.lamp = '0;
        if (in_i.set_time_btn) s.main_mode = M_SETTIME;
        if (in_i.manual_btn) begin
          s.main_mode   = M_MANUAL;
          s.return_mode = M_IDLE;
        end
        if (in_i.slow_btn) begin
          s.main_mode   = M_SLOW;
          s.return_mode = M_IDLE;
        end
        if (in_i.confirm_btn) s.main_mode = M_START;
      end
      M_SETTIME: begin
        s.lamp        = '0;
        s.main_mode   = M_SG1;
        s.digit_index = '0;
      end
      M_SG1: s = set_green(s, G1, M_SY1, in_i, cfg_i.set_to);
      M_SY1: s = set_yellow(s, G1, Y1, R2, 1'b0, in_i, cfg_i.set_to);
      M_SG2: s = set_green(s, G2, M_SY2, in_i, cfg_i.set_to);
      M_SY2: s = set_yellow(s, G2, Y2, R1, 1'b1, in_i, cfg_i.set_to);
      M_START: begin
        if (!s.times_set) begin
          if (in_i.confirm_btn) s.main_mode = M_IDLE;
        end else begin
          s.unlock_flag = 1'b0;
          s.main_mode   = M_G1R2;
          s.digit_index = '0;
        end
      end
      M_G1R2: begin
        s  = lset(s, LG, LR);
        c1 = s.run[G1];
        c2 = s.run[R2];
        if (strobe) begin
          s = dec(s, G1);
          s = dec(s, R2);
          s.second_strobe = 1'b0;
        end
        if (in_i.set_time_btn) s = req_set_time(s, 1'b1, M_G1R2, LG, LR);
        if (in_i.manual_btn) s = req_manual(s, M_G1R2);
        s = req_slow(s, M_G1R2, in_i.slow_btn, nt, 1'b0);
        s = req_del(s, M_G1R2, in_i.delete_btn);
        if (in_i.walk_req_one) begin
          s.return_mode = M_G1R2;
          s = lclr(s, LG, LR);
          s.main_mode = M_WALK;
          s.walk_step = 3'd0;
        end
        if (s.run[G1] == 7'd0) begin
          s = lclr(s, LG, L0);
          s.main_mode = M_Y1R2;
        end
      end
      M_Y1R2: begin
        s  = lset(s, LY, LR);
        c1 = s.run[Y1];
        c2 = s.run[R2];
        if (strobe) begin
          s = dec(s, Y1);
          s = dec(s, R2);
          s.second_strobe = 1'b0;
        end
        if (in_i.set_time_btn) s = req_set_time(s, 1'b1, M_Y1R2, LY, LR);
        if (in_i.manual_btn) s = req_manual(s, M_Y1R2);
        s = req_slow(s, M_Y1R2, in_i.slow_btn, nt, 1'b1);
        s = req_del(s, M_Y1R2, in_i.delete_btn);
        if (s.run[Y1] == 7'd0 || s.run[R2] == 7'd0) begin
          s = reload(s, G1);
          s = reload(s, Y1);
          s = reload(s, R2);
          s = lclr(s, LY, LR);
          s.main_mode = M_R1G2;
        end
      end
      M_R1G2: begin
        s  = lset(s, LR, LG);
        c1 = s.run[R1];
        c2 = s.run[G2];
        if (strobe) begin
          s = dec(s, R1);
          s = dec(s, G2);
          s.second_strobe = 1'b0;
        end
        if (in_i.set_time_btn) s = req_set_time(s, 1'b0, M_R1G2, LR, LG);
        if (in_i.manual_btn) s = req_manual(s, M_R1G2);
        s = req_slow(s, M_R1G2, in_i.slow_btn, nt, 1'b1);
        s = req_del(s, M_R1G2, in_i.delete_btn);
        if (in_i.walk_req_two) begin
          s.return_mode = M_R1G2;
          s = lclr(s, LR, LG);
          s.main_mode = M_WALK;
          s.walk_step = 3'd0;
        end
        if (s.run[G2] == 7'd0) begin
          s = lclr(s, L0, LG);
          s.main_mode = M_R1Y2;
        end
      end
      M_R1Y2: begin
        s  = lset(s, LR, LY);
        c1 = s.run[R1];
        c2 = s.run[Y2];
        if (strobe) begin
          s = dec(s, R1);
          s = dec(s, Y2);
          s.second_strobe = 1'b0;
        end
        s = req_slow(s, M_R1Y2, in_i.slow_btn, nt, 1'b1);
        s = req_del(s, M_R1Y2, in_i.delete_btn);
        if (in_i.set_time_btn) s = req_set_time(s, 1'b0, M_R1Y2, LR, LY);
        if (in_i.manual_btn) s = req_manual(s, M_R1Y2);
        if (s.run[Y2] == 7'd0 || s.run[R1] == 7'd0) begin
          s = reload(s, G2);
          s = reload(s, Y2);
          s = reload(s, R1);
          s = lclr(s, LR, LY);
          s.main_mode = M_START;
        end
      end
      M_SLOW: begin
        if (s.slow_step == S_FRESH) s.slow_step = nt ? S_NIGHT : S_KEY;
        if (strobe) begin
          if (!s.flash_toggle) begin
            s = lclr(s, LY, L0);
            s = lset(s, L0, LY);
            s.flash_toggle = 1'b1;
          end else begin
            s = lclr(s, L0, LY);
            s = lset(s, LY, L0);
            s.flash_toggle = 1'b0;
          end
          s.second_strobe = 1'b0;
        end
        if (in_i.set_time_btn) begin
          s = lclr(s, LY, LY);
          s.main_mode = M_SETTIME;
          s.slow_step = (s.slow_step == S_NIGHT) ? S_LEFT : S_FRESH;
        end
        if (in_i.confirm_btn) begin
          s = lclr(s, LY, LY);
          s.main_mode = s.return_mode;
          s.slow_step = (s.slow_step == S_NIGHT) ? S_LEFT : S_FRESH;
          if (s.main_mode != M_IDLE) s.unlock_flag = 1'b0;
        end
      end
      M_MANUAL: begin
        if (s.manual_step == 3'd0) begin
          if (s.return_mode == M_R1G2) s.manual_step = 3'd3;
          else if (s.return_mode == M_R1Y2) s.manual_step = 3'd4;
          else if (s.return_mode == M_G1R2 || s.return_mode == M_IDLE) s.manual_step = 3'd1;
          else if (s.return_mode == M_Y1R2) s.manual_step = 3'd2;
        end
        if (s.manual_step == 3'd1) begin
          s = lset(s, LG, LR);
          if (in_i.manual_btn) begin
            s = lclr(s, LG, L0);
            s.manual_step = 3'd2;
          end
        end else if (s.manual_step == 3'd2) begin
          s = lset(s, LY, LR);
          if (in_i.manual_btn) begin
            s = lclr(s, LY, LR);
            s.manual_step = 3'd3;
          end
        end else if (s.manual_step == 3'd3) begin
          s = lset(s, LR, LG);
          if (in_i.manual_btn) begin
            s = lclr(s, LR, LG);
            s.manual_step = 3'd4;
          end
        end else begin
          s = lset(s, LR, LY);
          if (in_i.manual_btn) begin
            s = lclr(s, LR, LY);
            s.manual_step = 3'd1;
          end
        end
        if (in_i.confirm_btn) begin
          s.lamp        = '0;
          s.manual_step = 3'd0;
          s.main_mode   = s.return_mode;
          if (s.main_mode != M_IDLE) s.unlock_flag = 1'b0;
        end
      end
      M_WALK: begin
        if (s.walk_step == 3'd0) begin
          if (s.return_mode == M_R1G2) begin
            s.walk_step = 3'd4;
            s.run[Y2]   = 7'd10;
          end else if (s.return_mode == M_G1R2) begin
            s.walk_step = 3'd1;
            s.run[Y1]   = 7'd10;
          end
        end
        if (s.walk_step == 3'd1) begin
          s  = lset(s, LY, LR);
          c1 = s.run[Y1];
          c2 = s.run[Y1];
          if (strobe) begin
            s = dec(s, Y1);
            s.second_strobe = 1'b0;
          end
          if (s.run[Y1] == 7'd0) begin
            s = lclr(s, LY, LR);
            s = reload(s, Y1);
            s.walk_step = 3'd2;
          end
        end else if (s.walk_step == 3'd2) begin
          s  = lset(s, LR, LG);
          c1 = s.run[R1];
          c2 = s.run[G2];
          if (strobe) begin
            s = dec(s, R1);
            s = dec(s, G2);
            s.second_strobe = 1'b0;
          end
          if (s.run[G2] == 7'd0) begin
            s = lclr(s, L0, LG);
            s.walk_step = 3'd3;
            s = reload(s, G2);
          end
        end else if (s.walk_step == 3'd3) begin
          s  = lset(s, LR, LY);
          c1 = s.run[R1];
          c2 = s.run[Y2];
          if (strobe) begin
            s = dec(s, R1);
            s = dec(s, Y2);
            s.second_strobe = 1'b0;
          end
          if (s.run[Y2] == 7'd0 || s.run[R1] == 7'd0) begin
            s = lclr(s, LR, LY);
            s.walk_step = 3'd0;
            s = reload(s, Y2);
            s = reload(s, R1);
            s = reload(s, R2);
            s = reload(s, G1);
            s.main_mode = M_G1R2;
          end
        end
        if (s.walk_step == 3'd4) begin
          s  = lset(s, LR, LY);
          c1 = s.run[Y2];
          c2 = s.run[Y2];
          if (strobe) begin
            s = dec(s, Y2);
            s.second_strobe = 1'b0;
          end
          if (s.run[Y2] == 7'd0) begin
            s = lclr(s, LR, LY);
            s = reload(s, Y2);
            s.walk_step = 3'd5;
          end
        end else if (s.walk_step == 3'd5) begin
          s  = lset(s, LG, LR);
          c1 = s.run[G1];
          c2 = s.run[R2];
          if (strobe) begin
            s = dec(s, R2);
            s = dec(s, G1);
            s.second_strobe = 1'b0;
          end
          if (s.run[G1] == 7'd0) begin
            s = lclr(s, LG, L0);
            s.walk_step = 3'd6;
            s = reload(s, G1);
          end
        end else if (s.walk_step == 3'd6) begin
          s  = lset(s, LY, LR);
          c1 = s.run[Y1];
          c2 = s.run[R2];
          if (strobe) begin
            s = dec(s, R2);
            s = dec(s, Y1);
            s.second_strobe = 1'b0;
          end
          if (s.run[R2] == 7'd0 || s.run[Y1] == 7'd0) begin
            s = lclr(s, LY, LR);
            s.walk_step = 3'd0;
            s = reload(s, R2);
            s = reload(s, Y1);
            s = reload(s, R1);
            s = reload(s, G2);
            s.main_mode = M_R1G2;
          end
        end
      end
      default: ;
    endcase

    if (c1 > 7'd99) c1 = 7'd99;
    if (c2 > 7'd99) c2 = 7'd99;
  end

  assign st_o            = s;
  assign res_o.lamps_one = s.lamp[0];
  assign res_o.lamps_two = s.lamp[1];
  assign res_o.count_one = c1;
  assign res_o.count_two = c2;
  assign res_o.mode_code = s.main_mode;
  assign res_o.unlocked  = s.unlock_flag;

endmodule

@@ sim/two_phase_traffic_light_controller_test.sv @@
// ----------------------------------------------------------------------------
// two_phase_traffic_light_controller_test
// Self-checking testbench of the two-phase traffic light controller.
// ----------------------------------------------------------------------------
// A short directed table walks the block from reset through login, time
// setting, the start of the countdown cycle and pedestrian mode. Random
// scenarios follow: logins with right and wrong codes, keypad time setting,
// running cycles with walk, manual, slow and delete requests, and noise.
// These run under several register settings, extremes among them. Every
// result transfer is compared field by field with the table's expected
// values or a tick-accurate model of the mode logic. Both handshakes idle
// at random, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module two_phase_traffic_light_controller_test;
  import tplc_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tplc_in_t  f;
    bit        chk;
    tplc_out_t e;
  } tick_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [3:0]  cfg_idx_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        confirm_btn_i = 1'b0;
  logic        delete_btn_i = 1'b0;
  logic        set_time_btn_i = 1'b0;
  logic        manual_btn_i = 1'b0;
  logic        slow_btn_i = 1'b0;
  logic        walk_req_one_i = 1'b0;
  logic        walk_req_two_i = 1'b0;
  logic        digit_valid_i = 1'b0;
  logic [3:0]  digit_value_i = '0;
  logic [4:0]  hour_now_i = 5'd12;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  lamps_one_o;
  logic [2:0]  lamps_two_o;
  logic [6:0]  count_one_o;
  logic [6:0]  count_two_o;
  logic [4:0]  mode_code_o;
  logic        unlocked_o;

  two_phase_traffic_light_controller u_dut (.*);

  always #10 clk_i = ~clk_i;

  // controller model state
  logic [15:0] code_reg[MaxCodes];
  logic [7:0]  tps_reg;
  logic [11:0] entry_to_reg, set_to_reg;
  logic [4:0]  mode, ret_mode, tgt_mode;
  logic [2:0]  man_step, walk_step, slow_step;
  logic [7:0]  tick_cnt;
  logic        sec_flag, flash, times_ok, unlock;
  logic [11:0] idle_cnt;
  logic [3:0]  dig_idx;
  logic [3:0]  code_dig[MaxDigits];
  logic [3:0]  time_dig[2];
  logic [6:0]  preset[6], run[6];
  logic [2:0]  lamp[2];

  tick_req_t   tick_q[$];
  tplc_out_t   result_q[$];
  tick_req_t   pending;
  int          n_err, n_ticks, n_results, burst_len, gap_len;
  bit          quiet;
  bit          hold_req;
  int          hold_cnt, stall_mode, stall_left;

  function automatic void ctl_reset();
    foreach (code_reg[k]) code_reg[k] = '0;
    tps_reg = 8'd20; entry_to_reg = 12'd200; set_to_reg = 12'd1000;
    mode = M_INIT; ret_mode = M_INIT; tgt_mode = '0;
    man_step = '0; walk_step = '0; slow_step = S_FRESH;
    tick_cnt = '0; sec_flag = 0; flash = 0; times_ok = 0; unlock = 0;
    idle_cnt = '0; dig_idx = '0;
    foreach (code_dig[d]) code_dig[d] = '0;
    time_dig[0] = '0; time_dig[1] = '0;
    foreach (run[i]) begin
      run[i] = '0; preset[i] = '0;
    end
    lamp[0] = L0; lamp[1] = L0;
  endfunction

  function automatic void dec_run(logic [2:0] i);
    if (run[i] != 0) run[i] = run[i] - 7'd1;
  endfunction

  function automatic void reload(logic [2:0] i);
    run[i] = preset[i];
  endfunction

  function automatic void lamp_clr(logic [2:0] m1, logic [2:0] m2);
    lamp[0] &= ~m1; lamp[1] &= ~m2;
  endfunction

  function automatic void lamp_set(logic [2:0] m1, logic [2:0] m2);
    lamp[0] |= m1; lamp[1] |= m2;
  endfunction

  function automatic void idle_inc();
    if (idle_cnt < 12'd4095) idle_cnt++;
  endfunction

  function automatic void idx_inc();
    if (dig_idx < 4'd15) dig_idx++;
  endfunction

  function automatic void go_set_time(bit save, logic [4:0] cur, logic [2:0] m1,
                                      logic [2:0] m2);
    if (save) ret_mode = cur;
    lamp_clr(m1, m2);
    mode = M_ENTER; tgt_mode = M_SETTIME;
  endfunction

  function automatic void go_manual(logic [4:0] cur);
    ret_mode = cur; lamp[0] = L0; lamp[1] = L0;
    mode = M_ENTER; tgt_mode = M_MANUAL; man_step = '0;
  endfunction

  function automatic void go_slow(logic [4:0] cur, bit slw, bit nt, bit always_tgt);
    if (!(slw || nt) || slow_step == S_LEFT) return;
    ret_mode = cur; lamp[0] = L0; lamp[1] = L0;
    if (slw) begin
      mode = M_ENTER; tgt_mode = M_SLOW;
    end else mode = M_SLOW;
    if (always_tgt) tgt_mode = M_SLOW;
    slow_step = S_FRESH;
  endfunction

  function automatic void go_delete(logic [4:0] cur, bit del);
    if (slow_step != S_LEFT || !del) return;
    ret_mode = cur; lamp[0] = L0; lamp[1] = L0;
    mode = M_ENTER; tgt_mode = M_SLOW; slow_step = S_NIGHT;
  endfunction

  function automatic void setting_exit(bit st);
    if (st) begin
      lamp[0] = L0; lamp[1] = L0; mode = M_SETTIME;
    end
    if (idle_cnt > set_to_reg) begin
      mode = M_IDLE; idle_cnt = '0;
    end
  endfunction

  function automatic void key_green(logic [2:0] gi, logic [4:0] nxt, tplc_in_t x);
    int v;
    idle_inc();
    if (x.digit_valid) begin
      if (dig_idx < 2) time_dig[dig_idx[0]] = x.digit_value;
      idx_inc();
    end
    if (x.delete_btn) dig_idx = '0;
    if (x.confirm_btn) begin
      v = (dig_idx == 1) ? 10 : time_dig[0] * 10 + time_dig[1];
      if (v > 90) v = 90;
      preset[gi] = v[6:0]; run[gi] = v[6:0];
      dig_idx = '0; mode = nxt;
    end
    setting_exit(x.set_time_btn);
  endfunction

  function automatic void key_yellow(logic [2:0] gi, logic [2:0] yi, logic [2:0] ri,
                                     bit last, tplc_in_t x);
    idle_inc();
    if (x.digit_valid) begin
      if (dig_idx < 1) time_dig[0] = x.digit_value;
      idx_inc(); idle_cnt = '0;
    end
    if (x.delete_btn) dig_idx = '0;
    if (x.confirm_btn) begin
      dig_idx = '0;
      preset[yi] = {3'd0, time_dig[0]}; run[yi] = preset[yi];
      preset[ri] = run[gi] + run[yi]; run[ri] = preset[ri];
      if (last) begin
        times_ok = 1; mode = M_IDLE;
      end else mode = M_SG2;
    end
    setting_exit(x.set_time_btn);
  endfunction

  function automatic bit code_ok();
    bit hit;
    for (int k = 0; k < MaxCodes; k++) begin
      hit = 1;
      for (int d = 0; d < MaxDigits; d++)
        if (code_dig[d] != code_reg[k][15-4*d -: 4]) hit = 0;
      if (hit) return 1;
    end
    return 0;
  endfunction

  function automatic tplc_out_t ctl_tick(tplc_in_t x);
    bit nt, strobe;
    logic [6:0] c1, c2;
    tplc_out_t o;
    nt = (x.hour_now <= 5'd4) || (x.hour_now == 5'd23);
    c1 = '0; c2 = '0;
    tick_cnt = tick_cnt + 8'd1;
    if (tps_reg != 0 && tick_cnt >= tps_reg) tick_cnt = '0;
    if (tick_cnt == 0) sec_flag = 1;
    strobe = sec_flag;
    case (mode)
      M_INIT: begin
        lamp[0] = L0; lamp[1] = L0;
        if (x.confirm_btn) begin
          dig_idx = '0; idle_cnt = '0; mode = M_ENTER; ret_mode = M_INIT;
        end
      end
      M_ENTER: begin
        idle_inc();
        if (x.digit_valid && !x.delete_btn) begin
          if (dig_idx < MaxDigits) code_dig[dig_idx[1:0]] = x.digit_value;
          idx_inc(); idle_cnt = '0;
        end
        if (x.delete_btn) begin
          dig_idx = '0; idle_cnt = '0;
        end
        if (x.confirm_btn) mode = M_CHECK;
        if (idle_cnt >= entry_to_reg) begin
          mode = ret_mode; idle_cnt = '0; dig_idx = '0;
        end
      end
      M_CHECK: begin
        idle_cnt = '0;
        if (code_ok()) begin
          if (tgt_mode == 0) mode = M_IDLE;
          else if (tgt_mode == M_SETTIME) mode = M_SETTIME;
          else if (tgt_mode == M_SLOW) mode = M_SLOW;
          else mode = M_MANUAL;
          unlock = 1; dig_idx = '0;
        end else mode = M_WRONG;
      end
      M_WRONG: begin
        idle_inc();
        if (x.confirm_btn) begin
          dig_idx = '0; idle_cnt = '0; mode = M_ENTER;
        end
      end
      M_IDLE: begin
        lamp[0] = L0; lamp[1] = L0;
        if (x.set_time_btn) mode = M_SETTIME;
        if (x.manual_btn) begin
          mode = M_MANUAL; ret_mode = M_IDLE;
        end
        if (x.slow_btn) begin
          mode = M_SLOW; ret_mode = M_IDLE;
        end
        if (x.confirm_btn) mode = M_START;
      end
      M_SETTIME: begin
        lamp[0] = L0; lamp[1] = L0; mode = M_SG1; dig_idx = '0;
      end
      M_SG1: key_green(G1, M_SY1, x);
      M_SY1: key_yellow(G1, Y1, R2, 0, x);
      M_SG2: key_green(G2, M_SY2, x);
      M_SY2: key_yellow(G2, Y2, R1, 1, x);
      M_START: begin
        if (!times_ok) begin
          if (x.confirm_btn) mode = M_IDLE;
        end else begin
          unlock = 0; mode = M_G1R2; dig_idx = '0;
        end
      end
      M_G1R2: begin
        lamp_set(LG, LR);
        c1 = run[G1]; c2 = run[R2];
        if (strobe) begin
          dec_run(G1); dec_run(R2); sec_flag = 0;
        end
        if (x.set_time_btn) go_set_time(1, M_G1R2, LG, LR);
        if (x.manual_btn) go_manual(M_G1R2);
        go_slow(M_G1R2, x.slow_btn, nt, 0);
        go_delete(M_G1R2, x.delete_btn);
        if (x.walk_req_one) begin
          ret_mode = M_G1R2; lamp_clr(LG, LR); mode = M_WALK; walk_step = '0;
        end
        if (run[G1] == 0) begin
          lamp_clr(LG, L0); mode = M_Y1R2;
        end
      end
      M_Y1R2: begin
        lamp_set(LY, LR);
        c1 = run[Y1]; c2 = run[R2];
        if (strobe) begin
          dec_run(Y1); dec_run(R2); sec_flag = 0;
        end
        if (x.set_time_btn) go_set_time(1, M_Y1R2, LY, LR);
        if (x.manual_btn) go_manual(M_Y1R2);
        go_slow(M_Y1R2, x.slow_btn, nt, 1);
        go_delete(M_Y1R2, x.delete_btn);
        if (run[Y1] == 0 || run[R2] == 0) begin
          reload(G1); reload(Y1); reload(R2);
          lamp_clr(LY, LR); mode = M_R1G2;
        end
      end
      M_R1G2: begin
        lamp_set(LR, LG);
        c1 = run[R1]; c2 = run[G2];
        if (strobe) begin
          dec_run(R1); dec_run(G2); sec_flag = 0;
        end
        if (x.set_time_btn) go_set_time(0, M_R1G2, LR, LG);
        if (x.manual_btn) go_manual(M_R1G2);
        go_slow(M_R1G2, x.slow_btn, nt, 1);
        go_delete(M_R1G2, x.delete_btn);
        if (x.walk_req_two) begin
          ret_mode = M_R1G2; lamp_clr(LR, LG); mode = M_WALK; walk_step = '0;
        end
        if (run[G2] == 0) begin
          lamp_clr(L0, LG); mode = M_R1Y2;
        end
      end
      M_R1Y2: begin
        lamp_set(LR, LY);
        c1 = run[R1]; c2 = run[Y2];
        if (strobe) begin
          dec_run(R1); dec_run(Y2); sec_flag = 0;
        end
        go_slow(M_R1Y2, x.slow_btn, nt, 1);
        go_delete(M_R1Y2, x.delete_btn);
        if (x.set_time_btn) go_set_time(0, M_R1Y2, LR, LY);
        if (x.manual_btn) go_manual(M_R1Y2);
        if (run[Y2] == 0 || run[R1] == 0) begin
          reload(G2); reload(Y2); reload(R1);
          lamp_clr(LR, LY); mode = M_START;
        end
      end
      M_SLOW: begin
        if (slow_step == S_FRESH) slow_step = nt ? S_NIGHT : S_KEY;
        if (strobe) begin
          if (!flash) begin
            lamp_clr(LY, L0); lamp_set(L0, LY); flash = 1;
          end else begin
            lamp_clr(L0, LY); lamp_set(LY, L0); flash = 0;
          end
          sec_flag = 0;
        end
        if (x.set_time_btn) begin
          lamp_clr(LY, LY); mode = M_SETTIME;
          slow_step = (slow_step == S_NIGHT) ? S_LEFT : S_FRESH;
        end
        if (x.confirm_btn) begin
          lamp_clr(LY, LY); mode = ret_mode;
          slow_step = (slow_step == S_NIGHT) ? S_LEFT : S_FRESH;
          if (mode != M_IDLE) unlock = 0;
        end
      end
      M_MANUAL: begin
        if (man_step == 0) begin
          if (ret_mode == M_R1G2) man_step = 3'd3;
          else if (ret_mode == M_R1Y2) man_step = 3'd4;
          else if (ret_mode == M_G1R2 || ret_mode == M_IDLE) man_step = 3'd1;
          else if (ret_mode == M_Y1R2) man_step = 3'd2;
        end
        if (man_step == 1) begin
          lamp_set(LG, LR);
          if (x.manual_btn) begin
            lamp_clr(LG, L0); man_step = 3'd2;
          end
        end else if (man_step == 2) begin
          lamp_set(LY, LR);
          if (x.manual_btn) begin
            lamp_clr(LY, LR); man_step = 3'd3;
          end
        end else if (man_step == 3) begin
          lamp_set(LR, LG);
          if (x.manual_btn) begin
            lamp_clr(LR, LG); man_step = 3'd4;
          end
        end else begin
          lamp_set(LR, LY);
          if (x.manual_btn) begin
            lamp_clr(LR, LY); man_step = 3'd1;
          end
        end
        if (x.confirm_btn) begin
          lamp[0] = L0; lamp[1] = L0; man_step = '0; mode = ret_mode;
          if (mode != M_IDLE) unlock = 0;
        end
      end
      M_WALK: begin
        if (walk_step == 0) begin
          if (ret_mode == M_R1G2) begin
            walk_step = 3'd4; run[Y2] = 7'd10;
          end else if (ret_mode == M_G1R2) begin
            walk_step = 3'd1; run[Y1] = 7'd10;
          end
        end
        if (walk_step == 1) begin
          lamp_set(LY, LR);
          c1 = run[Y1]; c2 = run[Y1];
          if (strobe) begin
            dec_run(Y1); sec_flag = 0;
          end
          if (run[Y1] == 0) begin
            lamp_clr(LY, LR); reload(Y1); walk_step = 3'd2;
          end
        end else if (walk_step == 2) begin
          lamp_set(LR, LG);
          c1 = run[R1]; c2 = run[G2];
          if (strobe) begin
            dec_run(R1); dec_run(G2); sec_flag = 0;
          end
          if (run[G2] == 0) begin
            lamp_clr(L0, LG); walk_step = 3'd3; reload(G2);
          end
        end else if (walk_step == 3) begin
          lamp_set(LR, LY);
          c1 = run[R1]; c2 = run[Y2];
          if (strobe) begin
            dec_run(R1); dec_run(Y2); sec_flag = 0;
          end
          if (run[Y2] == 0 || run[R1] == 0) begin
            lamp_clr(LR, LY); walk_step = '0;
            reload(Y2); reload(R1); reload(R2); reload(G1);
            mode = M_G1R2;
          end
        end
        if (walk_step == 4) begin
          lamp_set(LR, LY);
          c1 = run[Y2]; c2 = run[Y2];
          if (strobe) begin
            dec_run(Y2); sec_flag = 0;
          end
          if (run[Y2] == 0) begin
            lamp_clr(LR, LY); reload(Y2); walk_step = 3'd5;
          end
        end else if (walk_step == 5) begin
          lamp_set(LG, LR);
          c1 = run[G1]; c2 = run[R2];
          if (strobe) begin
            dec_run(R2); dec_run(G1); sec_flag = 0;
          end
          if (run[G1] == 0) begin
            lamp_clr(LG, L0); walk_step = 3'd6; reload(G1);
          end
        end else if (walk_step == 6) begin
          lamp_set(LY, LR);
          c1 = run[Y1]; c2 = run[R2];
          if (strobe) begin
            dec_run(R2); dec_run(Y1); sec_flag = 0;
          end
          if (run[R2] == 0 || run[Y1] == 0) begin
            lamp_clr(LY, LR); walk_step = '0;
            reload(R2); reload(Y1); reload(R1); reload(G2);
            mode = M_R1G2;
          end
        end
      end
      default: ;
    endcase
    if (c1 > 7'd99) c1 = 7'd99;
    if (c2 > 7'd99) c2 = 7'd99;
    o.lamps_one = lamp[0];
    o.lamps_two = lamp[1];
    o.count_one = c1;
    o.count_two = c2;
    o.mode_code = mode;
    o.unlocked  = unlock;
    return o;
  endfunction

  function automatic void check_field(string name, int e, int a);
    if (e != a) begin
      n_err++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
    end
  endfunction

  // result checking, tick prediction and sender
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (result_q.size() == 0) begin
          n_err++;
          $display("%0t: unexpected result transfer, mode %0d", $time, mode_code_o);
        end else begin
          check_field("lamps_one", result_q[0].lamps_one, lamps_one_o);
          check_field("lamps_two", result_q[0].lamps_two, lamps_two_o);
          check_field("count_one", result_q[0].count_one, count_one_o);
          check_field("count_two", result_q[0].count_two, count_two_o);
          check_field("mode_code", result_q[0].mode_code, mode_code_o);
          check_field("unlocked", result_q[0].unlocked, unlocked_o);
          void'(result_q.pop_front());
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pending = tick_q.pop_front();
        if (pending.chk) begin
          void'(ctl_tick(pending.f));
          result_q.push_back(pending.e);
        end else result_q.push_back(ctl_tick(pending.f));
        n_ticks++;
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (gap_len > 0) begin
          gap_len--;
          in_valid_i <= 1'b0;
        end else if (tick_q.size() > 0) begin
          in_valid_i     <= 1'b1;
          confirm_btn_i  <= tick_q[0].f.confirm_btn;
          delete_btn_i   <= tick_q[0].f.delete_btn;
          set_time_btn_i <= tick_q[0].f.set_time_btn;
          manual_btn_i   <= tick_q[0].f.manual_btn;
          slow_btn_i     <= tick_q[0].f.slow_btn;
          walk_req_one_i <= tick_q[0].f.walk_req_one;
          walk_req_two_i <= tick_q[0].f.walk_req_two;
          digit_valid_i  <= tick_q[0].f.digit_valid;
          digit_value_i  <= tick_q[0].f.digit_value;
          hour_now_i     <= tick_q[0].f.hour_now;
          if (burst_len > 0) burst_len--;
          else begin
            burst_len = $urandom_range(1, 40);
            if ($urandom_range(0, 7) == 0) quiet = ~quiet;
            gap_len = quiet ? 0 : $urandom_range(0, 6);
          end
        end else in_valid_i <= 1'b0;
      end
    end
  end

  // output stall pattern, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_cnt = 300;
      hold_req = 0;
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 120);
    end else stall_left--;
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_stall_i <= 1'b1;
    end else case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2: out_stall_i <= ($urandom_range(0, 1) == 0);
      default: out_stall_i <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic tplc_in_t plain_tick();
    tplc_in_t x;
    x = '0;
    x.hour_now = 5'($urandom_range(5, 22));
    return x;
  endfunction

  function automatic void add_tick(tplc_in_t x);
    tick_req_t r;
    r.f = x; r.chk = 0; r.e = '0;
    tick_q.push_back(r);
  endfunction

  function automatic void add_digit(logic [3:0] v);
    tplc_in_t x;
    x = plain_tick();
    x.digit_valid = 1; x.digit_value = v;
    add_tick(x);
  endfunction

  function automatic void add_confirm();
    tplc_in_t x;
    x = plain_tick();
    x.confirm_btn = 1;
    add_tick(x);
  endfunction

  function automatic void add_scenario();
    tplc_in_t x;
    logic [15:0] c;
    int n;
    case ($urandom_range(0, 9))
      0, 1: begin
        c = code_reg[$urandom_range(0, MaxCodes - 1)];
        if ($urandom_range(0, 4) == 0) c[3:0] = 4'($urandom_range(0, 9));
        add_confirm();
        for (int d = 0; d < MaxDigits; d++) add_digit(c[15-4*d -: 4]);
        add_confirm();
        add_tick(plain_tick());
      end
      2, 3: begin
        x = plain_tick(); x.set_time_btn = 1; add_tick(x);
        add_tick(plain_tick());
        for (int p = 0; p < 2; p++) begin
          n = $urandom_range(1, 2);
          for (int k = 0; k < n; k++) add_digit(k == 0 ? 4'($urandom_range(0, 1)) :
                                                4'($urandom_range(0, 9)));
          add_confirm();
          add_digit(4'($urandom_range(1, 9)));
          add_confirm();
        end
      end
      4, 5, 6: begin
        add_confirm();
        n = $urandom_range(5, 80);
        for (int k = 0; k < n; k++) begin
          x = plain_tick();
          case ($urandom_range(0, 60))
            0: x.walk_req_one = 1;
            1: x.walk_req_two = 1;
            2: x.manual_btn = 1;
            3: x.slow_btn = 1;
            4: x.delete_btn = 1;
            5: x.set_time_btn = 1;
            6: x.hour_now = 5'($urandom_range(0, 4));
            7: x.hour_now = 5'd23;
            default: ;
          endcase
          add_tick(x);
        end
      end
      7: begin
        x = plain_tick(); x.manual_btn = 1; add_tick(x);
        n = $urandom_range(2, 12);
        for (int k = 0; k < n; k++) begin
          x = plain_tick(); x.manual_btn = 1'($urandom_range(0, 1)); add_tick(x);
        end
        add_confirm();
      end
      8: begin
        x = plain_tick(); x.slow_btn = 1; add_tick(x);
        n = $urandom_range(2, 30);
        for (int k = 0; k < n; k++) begin
          x = plain_tick();
          if ($urandom_range(0, 1)) x.hour_now = 5'($urandom_range(0, 4));
          add_tick(x);
        end
        add_confirm();
      end
      default: begin
        n = $urandom_range(1, 10);
        for (int k = 0; k < n; k++) begin
          x = plain_tick();
          {x.confirm_btn, x.delete_btn, x.set_time_btn, x.manual_btn, x.slow_btn,
           x.walk_req_one, x.walk_req_two, x.digit_valid} = 8'($urandom);
          x.digit_value = 4'($urandom_range(0, 9));
          x.hour_now = 5'($urandom_range(0, 23));
          add_tick(x);
        end
      end
    endcase
  endfunction

  task automatic write_reg(logic [3:0] idx, logic [15:0] v);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= v;
    case (idx)
      CFG_TPS:   tps_reg = v[7:0];
      CFG_ENTRY: entry_to_reg = v[11:0];
      CFG_SET:   set_to_reg = v[11:0];
      default:   code_reg[idx[2:0]] = v;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_code();
    logic [15:0] c;
    for (int d = 0; d < 4; d++) c[4*d +: 4] = 4'($urandom_range(0, 9));
    return c;
  endfunction

  task automatic drain();
    while (tick_q.size() != 0 || in_valid_i || result_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  localparam int NPhases = 6;
  int tps_set[NPhases]   = '{1, 255, 2, 1, 3, 2};
  int entry_set[NPhases] = '{30, 4095, 1, 200, 60, 15};
  int setto_set[NPhases] = '{4095, 1, 1000, 40, 200, 4095};

  tick_req_t dir_tab[24];

  initial begin
    dir_tab = '{
      '{'{0,0,0,0,0,0,0,0,4'd0,5'd12}, 1, '{L0, L0, 7'd0, 7'd0, M_INIT, 1'b0}},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 1, '{L0, L0, 7'd0, 7'd0, M_ENTER, 1'b0}},
      '{'{0,1,0,0,0,0,0,1,4'd9,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd0,5'd0},  0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd0,5'd23}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd0,5'd16}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd0,5'd4},  0, '0},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 1, '{L0, L0, 7'd0, 7'd0, M_CHECK, 1'b0}},
      '{'{0,0,0,0,0,0,0,0,4'd0,5'd12}, 1, '{L0, L0, 7'd0, 7'd0, M_IDLE, 1'b1}},
      '{'{0,0,1,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd9,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd9,5'd12}, 0, '0},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd9,5'd12}, 0, '0},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd1,5'd12}, 0, '0},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,1,4'd5,5'd12}, 0, '0},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{1,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,0,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,0,0,1,0,0,4'd0,5'd12}, 0, '0},
      '{'{0,0,0,1,1,0,1,0,4'd8,5'd2},  0, '0}
    };
    n_err = 0; n_ticks = 0; n_results = 0;
    burst_len = 0; gap_len = 0; quiet = 0;
    hold_req = 0; hold_cnt = 0; stall_mode = 0; stall_left = 0;
    ctl_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) tick_q.push_back(dir_tab[i]);
    drain();

    for (int ph = 0; ph < NPhases; ph++) begin
      for (int k = 0; k < MaxCodes; k++)
        write_reg(4'(CFG_CODE0 + k), (ph == 1 && k == 0) ? 16'h9999 :
                                     (ph == 2 && k == 4) ? 16'h0000 : rand_code());
      write_reg(CFG_TPS, 16'(tps_set[ph]));
      write_reg(CFG_ENTRY, 16'(entry_set[ph]));
      write_reg(CFG_SET, 16'(setto_set[ph]));
      cfg_we_i <= 1'b0;
      if (ph == 3) hold_req = 1;
      while (tick_q.size() < 250) add_scenario();
      drain();
    end

    $display("%0d ticks sent, %0d results checked over %0d register settings",
             n_ticks, n_results, NPhases);
    if (n_err == 0) begin
      $display("** two_phase_traffic_light_controller: PASSED **");
    end else begin
      $display("%0d mismatches", n_err);
      $display("** two_phase_traffic_light_controller: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d ticks pending", tick_q.size());
    $display("** two_phase_traffic_light_controller: FAILED **");
    $finish;
  end

endmodule
